>>> hw/rtl/lkvc_pkg.sv
package lkvc_pkg;

  // Fixed field widths
  localparam int KeyW = 64;
  localparam int ValW = 32;
  localparam int CntW = 7;
  localparam int CtrW = 32;

  // Capacity register after reset
  localparam logic [CntW-1:0] CapReset = 7'd64;

  typedef enum logic [1:0] {
    OpLookup = 2'd0,
    OpInsert = 2'd1,
    OpClear  = 2'd2,
    OpNop    = 2'd3
  } lkvc_op_e;

  // One input word as held in the input register
  typedef struct packed {
    lkvc_op_e        op;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } lkvc_req_t;

  // Outcome of one word from the entry array
  typedef struct packed {
    logic            found;
    logic            lkp_hit;
    logic            evicted;
    logic [CntW:0]   ev_delta;
    logic [CntW-1:0] occupancy;
  } lkvc_resp_t;

endpackage

>>> hw/rtl/lkvc_lru_array.sv
module lkvc_lru_array
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  lkvc_req_t       req_i,
  input  logic [CntW-1:0] cap_i,
  output lkvc_resp_t      resp_o,
  output logic [ValW-1:0] rd_value_o
);

  localparam int IdxW = $clog2(ENTRIES);
  localparam int CmpW = (IdxW > CntW) ? IdxW : CntW;

  // Entry state: CAM rows of key, valid and recency rank
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [IdxW-1:0]    rank_q [ENTRIES];
  logic [IdxW-1:0]    rank_d [ENTRIES];
  logic [KeyW-1:0]    key_q  [ENTRIES];
  logic [CntW-1:0]    count_q, count_d;

  // Value memory with registered read
  logic [ValW-1:0]    val_mem [ENTRIES];
  logic [ValW-1:0]    rd_q;

  logic               is_clr, is_lkp, is_ins;
  logic               at_cap, over_cap;
  logic [CntW-1:0]    excess, cnt_trim, lim;
  logic [ENTRIES-1:0] below_cap, match, keep, free, first_free;
  logic               hit_any, ins_miss, ins_evict;
  logic [IdxW-1:0]    hit_idx, hit_rank, free_idx;
  logic [CntW:0]      ev_delta;

  always_comb begin
    is_clr = (req_i.op == OpClear);
    is_lkp = (req_i.op == OpLookup);
    is_ins = (req_i.op == OpInsert);

    // Trim entries past capacity from the least recent end
    over_cap = (count_q > cap_i);
    at_cap   = (count_q >= cap_i);
    excess   = over_cap ? (count_q - cap_i) : '0;
    cnt_trim = over_cap ? cap_i : count_q;

    // Compare the key against every surviving entry
    for (int i = 0; i < ENTRIES; i++) begin
      below_cap[i] = valid_q[i] && (CmpW'(rank_q[i]) < CmpW'(cap_i));
      match[i]     = below_cap[i] && (key_q[i] == req_i.key);
    end
    hit_any = |match;

    hit_idx  = '0;
    hit_rank = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_idx  = hit_idx | IdxW'(i);
        hit_rank = hit_rank | rank_q[i];
      end
    end

    // Insert of an absent key drops the oldest entry when full
    ins_miss  = is_ins && !hit_any;
    ins_evict = ins_miss && at_cap;
    lim       = ins_evict ? (cap_i - 1'b1) : cap_i;

    for (int i = 0; i < ENTRIES; i++) begin
      keep[i] = valid_q[i] && (CmpW'(rank_q[i]) < CmpW'(lim));
    end

    // Lowest free slot takes the new entry
    free       = ~keep;
    first_free = free & ~(free - 1'b1);
    free_idx   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_free[i]) begin
        free_idx = free_idx | IdxW'(i);
      end
    end

    // Next valid bits and ranks
    for (int i = 0; i < ENTRIES; i++) begin
      rank_d[i] = rank_q[i];
      if (is_clr) begin
        valid_d[i] = 1'b0;
      end else begin
        valid_d[i] = keep[i] || (ins_miss && first_free[i]);
      end
      if (ins_miss) begin
        if (first_free[i]) begin
          rank_d[i] = '0;
        end else if (keep[i]) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end else if (is_lkp && hit_any) begin
        if (match[i]) begin
          rank_d[i] = '0;
        end else if (below_cap[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + 1'b1;
        end
      end
    end

    if (is_clr) begin
      count_d = '0;
    end else if (ins_miss && !ins_evict) begin
      count_d = cnt_trim + 1'b1;
    end else begin
      count_d = cnt_trim;
    end

    ev_delta = is_clr ? '0 : ({1'b0, excess} + (CntW+1)'(ins_evict));

    resp_o.found     = hit_any && (is_lkp || is_ins);
    resp_o.lkp_hit   = hit_any && is_lkp;
    resp_o.evicted   = (ev_delta != '0);
    resp_o.ev_delta  = ev_delta;
    resp_o.occupancy = count_d;
  end

  // Hold control state of the entries
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (adv_i) begin
      valid_q <= valid_d;
      count_q <= count_d;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_q[i] <= rank_d[i];
      end
    end
  end

  // Write the key of a new entry
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (adv_i && ins_miss && first_free[i]) begin
        key_q[i] <= req_i.key;
      end
    end
  end

  // Value memory: write on insert of a new key, read the hit entry
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      if (ins_miss) begin
        val_mem[free_idx] <= req_i.value;
      end
      rd_q <= val_mem[hit_idx];
    end
  end

  assign rd_value_o = rd_q;

endmodule

>>> hw/rtl/lru_key_value_cache.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_ready_o   | operation_i, key_i, value_in_i
// out     | output    | out_valid_o / out_ready_i | found_o, value_out_o, evicted_o,
//         |           |                           | occupancy_o, *_total_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_data_i (capacity)
//
// One word per cycle while no result is stalled; a word passes the input register, then the result register.
// The rate is set by the single pass through the key CAM, rank update and
// free-slot search between the input register and the result register.
// Asynchronous reset empties the cache and zeroes the counters at once.
// A stalled result holds the output and lets one more word wait in the input
// register; the cfg port is always ready.
module lru_key_value_cache
  import lkvc_pkg::*;
#(
  parameter int ENTRIES = 64
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [ValW-1:0] value_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            found_o,
  output logic [ValW-1:0] value_out_o,
  output logic            evicted_o,
  output logic [CntW-1:0] occupancy_o,
  output logic [CtrW-1:0] hit_total_o,
  output logic [CtrW-1:0] miss_total_o,
  output logic [CtrW-1:0] eviction_total_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [CntW-1:0] cfg_data_i
);

  localparam int CapMaxI = (ENTRIES < (2 ** CntW - 1)) ? ENTRIES : (2 ** CntW - 1);
  localparam logic [CntW-1:0] CapMax = CntW'(CapMaxI);

  logic            in_valid_q;
  lkvc_req_t       req_q;
  logic            out_valid_q;
  logic            found_q, lkp_hit_q, evicted_q;
  logic [CntW-1:0] occ_q;
  logic [CtrW-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic [CtrW-1:0] hit_cnt_d, miss_cnt_d, evict_cnt_d;
  logic [CtrW:0]   evict_sum;
  logic [CntW-1:0] cap_q, cap_eff;
  logic            adv;
  lkvc_resp_t      resp;
  logic [ValW-1:0] rd_value;

  // Advance the input word when the result register is free or drains
  assign adv         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || adv;
  assign cfg_ready_o = 1'b1;

  // Clamp capacity to the usable range
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CntW'(1);
    end else if (cap_q > CapMax) begin
      cap_eff = CapMax;
    end else begin
      cap_eff = cap_q;
    end
  end

  lkvc_lru_array #(
    .ENTRIES (ENTRIES)
  ) u_array (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .req_i      (req_q),
    .cap_i      (cap_eff),
    .resp_o     (resp),
    .rd_value_o (rd_value)
  );

  // Saturating counters
  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_sum   = {1'b0, evict_cnt_q} + (CtrW+1)'(resp.ev_delta);
    evict_cnt_d = evict_sum[CtrW] ? '1 : evict_sum[CtrW-1:0];
    if (req_q.op == OpClear) begin
      hit_cnt_d   = '0;
      miss_cnt_d  = '0;
      evict_cnt_d = '0;
    end else if (req_q.op == OpLookup) begin
      if (resp.lkp_hit) begin
        if (hit_cnt_q != '1) begin
          hit_cnt_d = hit_cnt_q + 1'b1;
        end
      end else if (miss_cnt_q != '1) begin
        miss_cnt_d = miss_cnt_q + 1'b1;
      end
    end
  end

  // Hold control, result and counter registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      lkp_hit_q   <= 1'b0;
      evicted_q   <= 1'b0;
      occ_q       <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      cap_q       <= CapReset;
    end else begin
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        found_q     <= resp.found;
        lkp_hit_q   <= resp.lkp_hit;
        evicted_q   <= resp.evicted;
        occ_q       <= resp.occupancy;
        hit_cnt_q   <= hit_cnt_d;
        miss_cnt_q  <= miss_cnt_d;
        evict_cnt_q <= evict_cnt_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.op    <= lkvc_op_e'(operation_i);
      req_q.key   <= key_i;
      req_q.value <= value_in_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign found_o          = found_q;
  assign value_out_o      = lkp_hit_q ? rd_value : '0;
  assign evicted_o        = evicted_q;
  assign occupancy_o      = occ_q;
  assign hit_total_o      = hit_cnt_q;
  assign miss_total_o     = miss_cnt_q;
  assign eviction_total_o = evict_cnt_q;

endmodule

>>> verif/lru_key_value_cache_tb.sv
module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES = 64;
  localparam int LIMIT   = 400000;
  localparam int PHASE_WORDS = 180;

  typedef struct packed {
    logic            found;
    logic [ValW-1:0] value;
    logic            evicted;
    logic [CntW-1:0] occupancy;
    logic [CtrW-1:0] hit_total;
    logic [CtrW-1:0] miss_total;
    logic [CtrW-1:0] eviction_total;
  } cache_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [1:0]      operation_i = 2'd0;
  logic [KeyW-1:0] key_i = '0;
  logic [ValW-1:0] value_in_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic            found_o;
  logic [ValW-1:0] value_out_o;
  logic            evicted_o;
  logic [CntW-1:0] occupancy_o;
  logic [CtrW-1:0] hit_total_o;
  logic [CtrW-1:0] miss_total_o;
  logic [CtrW-1:0] eviction_total_o;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [CntW-1:0] cfg_data_i = '0;

  lru_key_value_cache #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .key_i           (key_i),
    .value_in_i      (value_in_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .value_out_o     (value_out_o),
    .evicted_o       (evicted_o),
    .occupancy_o     (occupancy_o),
    .hit_total_o     (hit_total_o),
    .miss_total_o    (miss_total_o),
    .eviction_total_o(eviction_total_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow copy of the cache contents and counters
  logic [KeyW-1:0] cache_key [ENTRIES];
  logic [ValW-1:0] cache_val [ENTRIES];
  logic            cache_live[ENTRIES];
  int              cache_age [ENTRIES];
  int              live_count = 0;
  logic [CtrW-1:0] hits = '0;
  logic [CtrW-1:0] misses = '0;
  logic [CtrW-1:0] evictions = '0;
  logic [CntW-1:0] capacity_reg = CapReset;

  lkvc_req_t       pending_words[$];
  cache_result_t   expected_results[$];
  logic [KeyW-1:0] key_pool[$];

  lkvc_req_t next_word;
  logic      in_fire = 1'b0;
  logic      out_fire = 1'b0;
  int        send_wait = 0;
  int        recv_wait = 0;
  int        send_gap_max = 10;
  int        recv_stall_max = 10;
  int        cycle_count = 0;
  int        mismatches = 0;

  initial begin
    for (int i = 0; i < ENTRIES; i++) begin
      cache_live[i] = 1'b0;
      cache_age[i]  = 0;
    end
  end

  function automatic logic [CtrW-1:0] bump(logic [CtrW-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic int find_slot(logic [KeyW-1:0] key);
    for (int i = 0; i < ENTRIES; i++)
      if (cache_live[i] && cache_key[i] == key) return i;
    return -1;
  endfunction

  // Drop the least recent entry and count it
  function automatic void drop_oldest();
    if (live_count == 0) return;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cache_live[i] && cache_age[i] == live_count - 1) begin
        cache_live[i] = 1'b0;
        cache_age[i]  = 0;
        break;
      end
    end
    live_count--;
    evictions = bump(evictions);
  endfunction

  // Apply one word to the shadow cache and return the result it must produce
  function automatic cache_result_t cache_step(lkvc_req_t w);
    cache_result_t r;
    int limit;
    int slot;
    int old_age;
    r = '0;
    limit = (capacity_reg == 0) ? 1 : (capacity_reg > ENTRIES) ? ENTRIES : int'(capacity_reg);
    if (w.op == OpClear) begin
      for (int i = 0; i < ENTRIES; i++) begin
        cache_live[i] = 1'b0;
        cache_age[i]  = 0;
      end
      live_count = 0;
      hits       = '0;
      misses     = '0;
      evictions  = '0;
    end else begin
      // trim down to a lowered capacity first
      while (live_count > limit) begin
        drop_oldest();
        r.evicted = 1'b1;
      end
      slot = find_slot(w.key);
      if (w.op == OpLookup) begin
        if (slot >= 0) begin
          r.found = 1'b1;
          r.value = cache_val[slot];
          hits = bump(hits);
          old_age = cache_age[slot];
          for (int i = 0; i < ENTRIES; i++)
            if (cache_live[i] && cache_age[i] < old_age) cache_age[i]++;
          cache_age[slot] = 0;
        end else begin
          misses = bump(misses);
        end
      end else if (w.op == OpInsert) begin
        if (slot >= 0) begin
          r.found = 1'b1;
        end else begin
          if (live_count >= limit) begin
            drop_oldest();
            r.evicted = 1'b1;
          end
          for (int i = 0; i < ENTRIES; i++)
            if (cache_live[i]) cache_age[i]++;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!cache_live[i]) begin
              cache_live[i] = 1'b1;
              cache_key[i]  = w.key;
              cache_val[i]  = w.value;
              cache_age[i]  = 0;
              live_count++;
              break;
            end
          end
        end
      end
    end
    r.occupancy      = CntW'(live_count);
    r.hit_total      = hits;
    r.miss_total     = misses;
    r.eviction_total = evictions;
    return r;
  endfunction

  function automatic void check_field(string tag, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, tag, want, got);
      mismatches++;
    end
  endfunction

  // Input driver: hold a word until taken, then idle or send the next one
  always @(negedge clk_i) begin
    if (!in_valid_i || in_fire) begin
      if (!rst_ni || send_wait > 0 || pending_words.size() == 0) begin
        if (send_wait > 0) send_wait--;
        in_valid_i  <= 1'b0;
        operation_i <= 2'($urandom_range(0, 3));
        key_i       <= {$urandom, $urandom};
        value_in_i  <= $urandom;
      end else begin
        next_word = pending_words.pop_front();
        in_valid_i  <= 1'b1;
        operation_i <= next_word.op;
        key_i       <= next_word.key;
        value_in_i  <= next_word.value;
        send_wait   = $urandom_range(0, send_gap_max);
      end
    end
  end

  // Result receiver: stall a random number of cycles after each word
  always @(negedge clk_i) begin
    if (out_fire) recv_wait = $urandom_range(0, recv_stall_max);
    else if (recv_wait > 0) recv_wait--;
    out_ready_i <= (recv_wait == 0);
  end

  // Monitor: predict on every accepted word, check every delivered result
  always @(posedge clk_i) begin
    cache_result_t want;
    in_fire  <= in_valid_i && in_ready_o;
    out_fire <= out_valid_o && out_ready_i;
    cycle_count <= cycle_count + 1;
    if (cfg_valid_i && cfg_ready_o) capacity_reg = cfg_data_i;
    if (in_valid_i && in_ready_o)
      expected_results.push_back(cache_step('{op: lkvc_op_e'(operation_i), key: key_i,
                                              value: value_in_i}));
    if (out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual found=%0b occ=%0d",
                 $time, found_o, occupancy_o);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("found", want.found, found_o);
        check_field("value_out", want.value, value_out_o);
        check_field("evicted", want.evicted, evicted_o);
        check_field("occupancy", want.occupancy, occupancy_o);
        check_field("hit_total", want.hit_total, hit_total_o);
        check_field("miss_total", want.miss_total, miss_total_o);
        check_field("eviction_total", want.eviction_total, eviction_total_o);
      end
    end
    if (cycle_count >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_word(lkvc_op_e op, logic [KeyW-1:0] key, logic [ValW-1:0] value);
    pending_words.push_back('{op: op, key: key, value: value});
  endtask

  // Wait until every queued word is sent and every result has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CntW-1:0] cap);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= cap;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase at a given capacity, key pool size and operation mix
  task automatic run_phase(logic [CntW-1:0] cap, int pool_n, int lookup_pct, int insert_pct,
                           int clear_pct, int gap_max, int stall_max);
    int pick;
    lkvc_op_e op;
    logic [KeyW-1:0] key;
    write_capacity(cap);
    key_pool.delete();
    for (int i = 0; i < pool_n; i++) key_pool.push_back({$urandom, $urandom});
    send_gap_max   = gap_max;
    recv_stall_max = stall_max;
    for (int n = 0; n < PHASE_WORDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < lookup_pct) op = OpLookup;
      else if (pick < lookup_pct + insert_pct) op = OpInsert;
      else if (pick < lookup_pct + insert_pct + clear_pct) op = OpClear;
      else op = OpNop;
      pick = $urandom_range(0, 99);
      if (pick < 3) key = '0;
      else if (pick < 6) key = '1;
      else if (pick < 16) key = {$urandom, $urandom};
      else key = key_pool[$urandom_range(0, pool_n - 1)];
      push_word(op, key, $urandom);
    end
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty miss, extreme keys and values, duplicate insert, nop, clear
    push_word(OpLookup, '0, '0);
    push_word(OpInsert, '0, '0);
    push_word(OpInsert, '1, '1);
    push_word(OpLookup, '1, '0);
    push_word(OpLookup, '0, '1);
    push_word(OpInsert, '0, 32'h1234_5678);
    push_word(OpLookup, '0, '0);
    push_word(OpLookup, 64'h5a5a_5a5a_5a5a_5a5a, '0);
    push_word(OpNop, 64'hdead_beef_0000_0001, 32'h8000_0001);
    push_word(OpInsert, 64'h1, 32'h11);
    push_word(OpInsert, 64'h2, 32'h22);
    push_word(OpClear, '1, '1);
    push_word(OpLookup, '1, '0);
    push_word(OpInsert, 64'ha5a5_a5a5_a5a5_a5a5, 32'ha5a5_a5a5);
    push_word(OpInsert, 64'h1, 32'h101);
    push_word(OpInsert, 64'h2, 32'h202);
    push_word(OpInsert, 64'h3, 32'h303);
    wait_idle();

    // Lowered capacity: trim happens on the next word, even a nop
    write_capacity(7'd2);
    push_word(OpNop, '0, '0);
    push_word(OpInsert, 64'h4, 32'h404);
    push_word(OpLookup, 64'h3, '0);
    push_word(OpLookup, 64'ha5a5_a5a5_a5a5_a5a5, '0);
    wait_idle();

    // Random phases: fill, trim from full, tiny and out-of-range capacities
    run_phase(7'd64, 200, 30, 70, 0, 10, 10);
    run_phase(7'd3, 6, 45, 45, 2, 0, 0);
    run_phase(7'd1, 3, 45, 45, 2, 10, 0);
    run_phase(7'd0, 3, 45, 45, 2, 0, 10);
    run_phase(7'd127, 120, 35, 65, 0, 3, 3);
    run_phase(7'd65, 90, 50, 45, 1, 10, 10);
    run_phase(7'd2, 4, 45, 45, 3, 0, 0);
    run_phase(7'd16, 26, 50, 42, 2, 10, 10);
    run_phase(7'd64, 90, 50, 44, 2, 5, 0);
    run_phase(CntW'($urandom_range(1, 127)), 40, 45, 45, 3, 10, 10);

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
